// ===== rtl/core/cmb_pkg.sv =====
// Package for the coverage max-blend ARGB4444 blitter.
// Holds sizes, register indexes, item kinds, shared structs and the divide-by-15 helper.
// No dependencies; every other file of the block but cmb_ram imports it.
`default_nettype none

package cmb_pkg;

	// Store geometry and framebuffer layout.
	localparam int MAX_BOX_WIDTH  = 512;
	localparam int MAX_BOX_HEIGHT = 64;
	localparam int LINE_STRIDE    = 2048;
	localparam int MAX_PAGES      = 4;

	localparam int STORE_DEPTH  = MAX_BOX_WIDTH * MAX_BOX_HEIGHT;
	localparam int COL_W        = $clog2(MAX_BOX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_BOX_HEIGHT);
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int STRIDE_BYTES = 2 * LINE_STRIDE;
	localparam int PAGE_CNT_W   = $clog2(MAX_PAGES + 1);

	// Item and result field widths.
	localparam int FUNC_W  = 2;
	localparam int POSX_W  = 11;
	localparam int POSY_W  = 8;
	localparam int COV_W   = 8;
	localparam int OFF_W   = 27;
	localparam int PIX_W   = 16;
	localparam int PIDX_W  = 2;
	localparam int NIB_W   = 4;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Configuration port.
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COLOR      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PAGE_ROWS  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_PAGE_COUNT = 3'd6;

	// Reset values of the registers.
	localparam logic [9:0]  RST_BOX_WIDTH  = 10'd512;
	localparam logic [6:0]  RST_BOX_HEIGHT = 7'd38;
	localparam logic [11:0] RST_COLOR      = 12'hFFF;
	localparam logic [10:0] RST_ORIGIN_X   = 11'd0;
	localparam logic [11:0] RST_ORIGIN_Y   = 12'd0;
	localparam logic [11:0] RST_PAGE_ROWS  = 12'd1080;
	localparam logic [2:0]  RST_PAGE_COUNT = 3'd1;

	// Reciprocal of 15 for values up to 225: floor(x/15) = (x*137) >> 11.
	localparam int DIV15_MUL   = 137;
	localparam int DIV15_SHIFT = 11;

	// Item function codes.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_BLEND = 2'd0,
		FUNC_EMIT  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	// Configuration register file.
	typedef struct packed {
		logic [9:0]  box_width;
		logic [6:0]  box_height;
		logic [11:0] color;
		logic [10:0] origin_x;
		logic [11:0] origin_y;
		logic [11:0] page_rows;
		logic [2:0]  page_count;
	} cmb_cfg_t;

	// A classified item waiting for the back end.
	typedef struct packed {
		func_t             kind;
		logic [ADDR_W-1:0] addr;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [COV_W-1:0]  cov;
	} cmb_op_t;

	// Status from the back end to the front end.
	typedef struct packed {
		logic clearing;
	} cmb_stat_t;

	// Floor of x/15 for x up to 225, by reciprocal multiplication.
	function automatic logic [NIB_W-1:0] div15(input logic [7:0] x);
		logic [15:0] p;
		p = 16'(x) * 16'(DIV15_MUL);
		return p[DIV15_SHIFT +: NIB_W];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cmb_ifs.sv =====
// Valid/ready channel interfaces for the blitter's item input and result output.
// Depends on cmb_pkg for field widths.
`default_nettype none

interface cmb_item_if import cmb_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [POSX_W-1:0] pos_x;
	logic signed [POSY_W-1:0] pos_y;
	logic [COV_W-1:0]         coverage;

	modport source (output valid, func, pos_x, pos_y, coverage, input ready);
	modport sink   (input valid, func, pos_x, pos_y, coverage, output ready);
endinterface

interface cmb_result_if import cmb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OFF_W-1:0]  fb_byte_offset;
	logic [PIX_W-1:0]  pixel_word;
	logic [PIDX_W-1:0] page_index;
	logic              last;

	modport source (output valid, fb_byte_offset, pixel_word, page_index, last, input ready);
	modport sink   (input valid, fb_byte_offset, pixel_word, page_index, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cmb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cmb_queue.sv =====
// Short FIFO of classified items between the front and back ends.
// Depends on cmb_pkg for the entry type and depth.
`default_nettype none

module cmb_queue import cmb_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  cmb_op_t      push_op,
	input  wire logic    pop,
	output cmb_op_t      head,
	output logic         empty,
	output logic         full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmb_op_t           entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cmb_front.sv =====
// Front end: accepts items, clips positions to the box and queues real work.
// Depends on cmb_pkg and the item interface in cmb_ifs.
`default_nettype none

module cmb_front import cmb_pkg::*; (
	cmb_item_if.sink     items,
	input  cmb_cfg_t     cfg,
	input  cmb_stat_t    stat,
	input  wire logic    q_full,
	output logic         push,
	output cmb_op_t      push_op
);

	logic [9:0] bw_eff;
	logic [6:0] bh_eff;
	logic [9:0] px_u;
	logic [6:0] py_u;
	logic       x_ok;
	logic       y_ok;
	logic       func_ok;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;

	// Hold off items while the store is being cleared or the queue is full.
	assign items.ready = !q_full && !stat.clearing;

	// Clip the signed position to the clamped box size.
	always_comb begin
		bw_eff  = (cfg.box_width == '0) ? 10'd1 : cfg.box_width;
		bh_eff  = (cfg.box_height == '0) ? 7'd1 : cfg.box_height;
		px_u    = items.pos_x[9:0];
		py_u    = items.pos_y[6:0];
		x_ok    = !items.pos_x[POSX_W-1] && (px_u < bw_eff) && (int'(px_u) < MAX_BOX_WIDTH);
		y_ok    = !items.pos_y[POSY_W-1] && (py_u < bh_eff) && (int'(py_u) < MAX_BOX_HEIGHT);
		func_ok = (items.func == FUNC_BLEND) || (items.func == FUNC_EMIT) ||
			(items.func == FUNC_CLEAR);
		col     = COL_W'(px_u);
		row     = ROW_W'(py_u);
	end

	// Build the queue entry; dropped items are accepted but not queued.
	always_comb begin
		push_op.kind = func_t'(items.func);
		push_op.addr = ADDR_W'(row) * ADDR_W'(MAX_BOX_WIDTH) + ADDR_W'(col);
		push_op.col  = col;
		push_op.row  = row;
		push_op.cov  = items.coverage;
		push         = items.valid && items.ready && x_ok && y_ok && func_ok;
	end

endmodule

`default_nettype wire

// ===== rtl/core/cmb_back.sv =====
// Back end: clears the coverage store after reset, runs blends, clears and emits.
// Depends on cmb_pkg, cmb_ram and the result interface in cmb_ifs.
`default_nettype none

module cmb_back import cmb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  cmb_cfg_t       cfg,
	input  cmb_op_t        head,
	input  wire logic      q_empty,
	output logic           pop,
	output cmb_stat_t      stat,
	cmb_result_if.source   results
);

	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_READ = 5'b00100,
		ST_PIX  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t                state_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [PAGE_CNT_W-1:0] page_q;
	logic                  res_valid_q;

	cmb_op_t               op_q;
	logic [NIB_W-1:0]      alpha_q;
	logic [7:0]            prod_r_q;
	logic [7:0]            prod_g_q;
	logic [7:0]            prod_b_q;
	logic [PIX_W-1:0]      pix_q;
	logic [OFF_W-1:0]      fy_q;
	logic [OFF_W-1:0]      xoff_q;
	logic [OFF_W-1:0]      res_off_q;
	logic [PIX_W-1:0]      res_pix_q;
	logic [PIDX_W-1:0]     res_page_q;
	logic                  res_last_q;

	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	logic [COV_W-1:0]      wdata;
	logic                  re;
	logic [COV_W-1:0]      rdata;
	logic [NIB_W-1:0]      rd_alpha;
	logic [PAGE_CNT_W-1:0] pages_eff;
	logic [PAGE_CNT_W-1:0] page_nx;
	logic                  page_last;
	logic                  out_free;
	logic                  load;

	cmb_ram #(
		.WIDTH (COV_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (head.addr),
		.rdata (rdata)
	);

	assign stat.clearing = (state_q == ST_CLR);
	assign rd_alpha      = rdata[COV_W-1 -: NIB_W];

	// Page count clamp and last-page detection.
	always_comb begin
		if (cfg.page_count == '0) begin
			pages_eff = PAGE_CNT_W'(1);
		end else if (int'(cfg.page_count) > MAX_PAGES) begin
			pages_eff = PAGE_CNT_W'(MAX_PAGES);
		end else begin
			pages_eff = PAGE_CNT_W'(cfg.page_count);
		end
		page_nx   = page_q + PAGE_CNT_W'(1);
		page_last = (page_nx == pages_eff);
	end

	// Store port control: clearing sweep, clear items, blend write-back, reads.
	always_comb begin
		pop   = (state_q == ST_IDLE) && !q_empty;
		re    = pop && (head.kind != FUNC_CLEAR);
		we    = 1'b0;
		waddr = head.addr;
		wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			ST_IDLE: begin
				we = pop && (head.kind == FUNC_CLEAR);
			end
			ST_READ: begin
				we    = (op_q.kind == FUNC_BLEND) && (op_q.cov > rdata);
				waddr = op_q.addr;
				wdata = op_q.cov;
			end
			ST_PIX, ST_EMIT: begin
				we = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Output register takes a new page when empty or being drained.
	assign out_free = !res_valid_q || results.ready;
	assign load     = (state_q == ST_EMIT) && out_free;

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			page_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (re) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= (op_q.kind == FUNC_EMIT) ? ST_PIX : ST_IDLE;
				end
				ST_PIX: begin
					page_q  <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						page_q <= page_nx;
						if (page_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: operation latch, colour products, pixel word and page offsets.
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head;
		end
		if (state_q == ST_READ) begin
			alpha_q  <= rd_alpha;
			prod_r_q <= cfg.color[11:8] * rd_alpha;
			prod_g_q <= cfg.color[7:4] * rd_alpha;
			prod_b_q <= cfg.color[3:0] * rd_alpha;
		end
		if (state_q == ST_PIX) begin
			pix_q  <= {alpha_q, div15(prod_r_q), div15(prod_g_q), div15(prod_b_q)};
			fy_q   <= OFF_W'(cfg.origin_y) + OFF_W'(op_q.row);
			xoff_q <= (OFF_W'(cfg.origin_x) + OFF_W'(op_q.col)) << 1;
		end
		if (load) begin
			res_off_q  <= fy_q * OFF_W'(STRIDE_BYTES) + xoff_q;
			res_pix_q  <= pix_q;
			res_page_q <= PIDX_W'(page_q);
			res_last_q <= page_last;
			fy_q       <= fy_q + OFF_W'(cfg.page_rows);
		end
	end

	assign results.valid          = res_valid_q;
	assign results.fb_byte_offset = res_off_q;
	assign results.pixel_word     = res_pix_q;
	assign results.page_index     = res_page_q;
	assign results.last           = res_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/coverage_maxblend_argb4444_blit.sv =====
// Top level of the coverage max-blend ARGB4444 blitter: APB registers and block wiring.
// Depends on cmb_pkg, cmb_ifs, cmb_front, cmb_queue and cmb_back.
//
//  Channel   Dir  Handshake              Payload
//  items     in   valid/ready            func, pos_x, pos_y, coverage
//  results   out  valid/ready            fb_byte_offset, pixel_word, page_index, last
//  APB       in   psel/penable/pwrite    paddr, pwdata -> prdata, pready tied high
//
// The front end takes one item per cycle into a two-entry queue while it has room and
// no clearing sweep runs. The back end, limited by the single coverage RAM, does a
// clear as a write from idle, a blend as a read then a write-back, and an emit as a
// read, a pixel step and one result per page. After reset it sweeps the 32768-entry
// store to zero, one entry per cycle; items wait for the sweep, configuration writes do not.
// A stalled result holds in the output register while the queue keeps filling.
`default_nettype none

module coverage_maxblend_argb4444_blit import cmb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	cmb_item_if.sink                items,
	cmb_result_if.source            results
);

	cmb_cfg_t              cfg_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  wr_en;
	logic                  push;
	cmb_op_t               push_op;
	cmb_op_t               head;
	logic                  q_empty;
	logic                  q_full;
	logic                  pop;
	cmb_stat_t             stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_width  <= RST_BOX_WIDTH;
			cfg_q.box_height <= RST_BOX_HEIGHT;
			cfg_q.color      <= RST_COLOR;
			cfg_q.origin_x   <= RST_ORIGIN_X;
			cfg_q.origin_y   <= RST_ORIGIN_Y;
			cfg_q.page_rows  <= RST_PAGE_ROWS;
			cfg_q.page_count <= RST_PAGE_COUNT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BOX_WIDTH:  cfg_q.box_width  <= pwdata[9:0];
				REG_BOX_HEIGHT: cfg_q.box_height <= pwdata[6:0];
				REG_COLOR:      cfg_q.color      <= pwdata[11:0];
				REG_ORIGIN_X:   cfg_q.origin_x   <= pwdata[10:0];
				REG_ORIGIN_Y:   cfg_q.origin_y   <= pwdata[11:0];
				REG_PAGE_ROWS:  cfg_q.page_rows  <= pwdata[11:0];
				REG_PAGE_COUNT: cfg_q.page_count <= pwdata[2:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			REG_BOX_WIDTH:  prdata = PDATA_W'(cfg_q.box_width);
			REG_BOX_HEIGHT: prdata = PDATA_W'(cfg_q.box_height);
			REG_COLOR:      prdata = PDATA_W'(cfg_q.color);
			REG_ORIGIN_X:   prdata = PDATA_W'(cfg_q.origin_x);
			REG_ORIGIN_Y:   prdata = PDATA_W'(cfg_q.origin_y);
			REG_PAGE_ROWS:  prdata = PDATA_W'(cfg_q.page_rows);
			REG_PAGE_COUNT: prdata = PDATA_W'(cfg_q.page_count);
			default:        prdata = '0;
		endcase
	end

	cmb_front u_front (
		.items   (items),
		.cfg     (cfg_q),
		.stat    (stat),
		.q_full  (q_full),
		.push    (push),
		.push_op (push_op)
	);

	cmb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	cmb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.stat    (stat),
		.results (results)
	);

endmodule

`default_nettype wire
